// ----- sv/swhsr_pkg.sv -----
// Package: shared types and constants for the single-wire humidity sensor reader.
`timescale 1ns / 1ps
`default_nettype none
package swhsr_pkg;

   localparam int FRAME_BITS  = 40;
   localparam int FRAME_BYTES = FRAME_BITS / 8;
   localparam int BITCNT_W    = $clog2(FRAME_BITS + 1);
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] START_LOW_RST  = 16'd18000;
   localparam logic [7:0]  RELEASE_RST    = 8'd30;
   localparam logic [7:0]  RESP_WAIT_RST  = 8'd40;
   localparam logic [7:0]  RESP_GAP_RST   = 8'd80;
   localparam logic [7:0]  BIT_THRESH_RST = 8'd40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_LOW  = 3'd0,
      CSR_RELEASE    = 3'd1,
      CSR_RESP_WAIT  = 3'd2,
      CSR_RESP_GAP   = 3'd3,
      CSR_BIT_THRESH = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START_LOW = 4'd1,
      PH_RELEASE   = 4'd2,
      PH_RESP_LOW  = 4'd3,
      PH_RESP_HIGH = 4'd4,
      PH_PRE_DATA  = 4'd5,
      PH_BIT_LOW   = 4'd6,
      PH_BIT_HIGH  = 4'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_LOW   = 2'd1,
      ST_NO_HIGH  = 2'd2,
      ST_CHECKSUM = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] start_low;
      logic [7:0]  release_t;
      logic [7:0]  resp_wait;
      logic [7:0]  resp_gap;
      logic [7:0]  bit_thresh;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic [1:0] status;
      logic [7:0] humidity;
      logic [7:0] temperature;
   } result_type;

endpackage
`default_nettype wire

// ----- sv/swhsr_core.sv -----
// Protocol sequencer: phase, tick and bit counters, frame shifter and last reading.
`timescale 1ns / 1ps
`default_nettype none
module swhsr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic                 start,
   input  wire logic                 line,
   input  wire swhsr_pkg::cfg_type   cfg,
   output swhsr_pkg::result_type     result
);
   import swhsr_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [BITCNT_W-1:0]      bitcnt_ff, bitcnt_in;
   logic [FRAME_BITS-1:0]    frame_ff, frame_in;
   logic [7:0]               hum_ff, hum_in;
   logic [7:0]               temp_ff, temp_in;
   logic [1:0]               status_ff, status_in;

   logic [TICK_W-1:0]        tick_sat;
   logic [TICK_W-1:0]        limit;
   logic                     wait_hit;
   logic                     done;
   logic                     bit_val;
   logic [FRAME_BITS-1:0]    frame_shifted;
   logic [BITCNT_W-1:0]      bitcnt_inc;
   logic [7:0]               byte_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bitcnt_ff <= '0;
         frame_ff  <= '0;
         hum_ff    <= '0;
         temp_ff   <= '0;
         status_ff <= ST_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bitcnt_ff <= bitcnt_in;
         frame_ff  <= frame_in;
         hum_ff    <= hum_in;
         temp_ff   <= temp_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      tick_sat = (tick_ff == {TICK_W{1'b1}}) ? tick_ff : tick_ff + 1'b1;
      unique case (phase_ff)
         PH_START_LOW: limit = cfg.start_low;
         PH_RELEASE:   limit = {8'd0, cfg.release_t};
         PH_RESP_LOW:  limit = {8'd0, cfg.resp_wait};
         default:      limit = {8'd0, cfg.resp_gap};
      endcase
      wait_hit      = tick_sat >= limit;
      bit_val       = tick_ff > {8'd0, cfg.bit_thresh};
      frame_shifted = {frame_ff[FRAME_BITS-2:0], bit_val};
      bitcnt_inc    = bitcnt_ff + 1'b1;
      byte_sum      = 8'd0;
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
         byte_sum = byte_sum + frame_shifted[FRAME_BITS-1-8*k -: 8];
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bitcnt_in = bitcnt_ff;
      frame_in  = frame_ff;
      hum_in    = hum_ff;
      temp_in   = temp_ff;
      status_in = status_ff;
      done      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in  = PH_START_LOW;
               tick_in   = '0;
               bitcnt_in = '0;
               frame_in  = '0;
            end
         end
         PH_START_LOW, PH_RELEASE, PH_PRE_DATA: begin
            tick_in = tick_sat;
            if (wait_hit) begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_START_LOW: phase_in = PH_RELEASE;
                  PH_RELEASE:   phase_in = PH_RESP_LOW;
                  default:      phase_in = PH_BIT_LOW;
               endcase
            end
         end
         PH_RESP_LOW: begin
            tick_in = tick_sat;
            if (wait_hit) begin
               tick_in = '0;
               if (line) begin
                  phase_in  = PH_IDLE;
                  status_in = ST_NO_LOW;
                  done      = 1'b1;
               end else begin
                  phase_in = PH_RESP_HIGH;
               end
            end
         end
         PH_RESP_HIGH: begin
            tick_in = tick_sat;
            if (wait_hit) begin
               tick_in = '0;
               if (!line) begin
                  phase_in  = PH_IDLE;
                  status_in = ST_NO_HIGH;
                  done      = 1'b1;
               end else begin
                  phase_in = PH_PRE_DATA;
               end
            end
         end
         PH_BIT_LOW: begin
            if (line) begin
               phase_in = PH_BIT_HIGH;
               tick_in  = {{(TICK_W-1){1'b0}}, 1'b1};
            end
         end
         PH_BIT_HIGH: begin
            if (line) begin
               tick_in = tick_sat;
            end else begin
               frame_in  = frame_shifted;
               bitcnt_in = bitcnt_inc;
               tick_in   = '0;
               phase_in  = PH_BIT_LOW;
               if (bitcnt_inc >= BITCNT_W'(FRAME_BITS)) begin
                  bitcnt_in = '0;
                  phase_in  = PH_IDLE;
                  done      = 1'b1;
                  if (byte_sum != frame_shifted[7:0]) begin
                     status_in = ST_CHECKSUM;
                  end else begin
                     status_in = ST_OK;
                     hum_in    = frame_shifted[FRAME_BITS-1 -: 8];
                     temp_in   = frame_shifted[FRAME_BITS-17 -: 8];
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   assign result.drive_low   = (phase_in == PH_START_LOW);
   assign result.busy        = (phase_in != PH_IDLE);
   assign result.done        = done;
   assign result.status      = status_in;
   assign result.humidity    = hum_in;
   assign result.temperature = temp_in;

   a_idle_tick_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_ff == '0)
      else $error("tick counter not cleared in idle");

   a_bitcnt_range: assert property (@(posedge clock) disable iff (reset)
      bitcnt_ff < BITCNT_W'(FRAME_BITS))
      else $error("bit counter out of range");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      result.done |-> !result.busy)
      else $error("done reported while still busy");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && !start |=> phase_ff == PH_IDLE)
      else $error("left idle without a start");

endmodule
`default_nettype wire

// ----- sv/single_wire_humidity_sensor_reader.sv -----
// Top level: CSR block, word handshake and result register around the sequencer.
// Latency: a result word is valid the cycle after its request word is accepted.
// Throughput: one request word per cycle while req_ready is high; the sequencer state advances once per word.
// A request word is taken whenever the result register is empty or being drained.
// Reset (synchronous): sequencer to idle, counters and last reading to zero,
// CSRs to their defaults, result register empty.
`timescale 1ns / 1ps
`default_nettype none
module single_wire_humidity_sensor_reader (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_start_req,
   input  wire logic                               req_line_level,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_drive_low,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic [1:0]                              rsp_status,
   output logic [7:0]                              rsp_humidity,
   output logic [7:0]                              rsp_temperature,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [swhsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swhsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import swhsr_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low  <= START_LOW_RST;
         cfg_ff.release_t  <= RELEASE_RST;
         cfg_ff.resp_wait  <= RESP_WAIT_RST;
         cfg_ff.resp_gap   <= RESP_GAP_RST;
         cfg_ff.bit_thresh <= BIT_THRESH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_LOW:  cfg_ff.start_low  <= csr_wdata;
            CSR_RELEASE:    cfg_ff.release_t  <= csr_wdata[7:0];
            CSR_RESP_WAIT:  cfg_ff.resp_wait  <= csr_wdata[7:0];
            CSR_RESP_GAP:   cfg_ff.resp_gap   <= csr_wdata[7:0];
            CSR_BIT_THRESH: cfg_ff.bit_thresh <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   swhsr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .start  (req_start_req),
      .line   (req_line_level),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_low   = rsp_ff.drive_low;
   assign rsp_busy_res    = rsp_ff.busy;
   assign rsp_done_res    = rsp_ff.done;
   assign rsp_status      = rsp_ff.status;
   assign rsp_humidity    = rsp_ff.humidity;
   assign rsp_temperature = rsp_ff.temperature;

endmodule
`default_nettype wire
